// ===== hw/rtl/imt_pkg.sv =====
// Shared types and constants for the iterative mean threshold block.
// No dependencies; imported by the top level and the checker of the block.
`timescale 1ns / 1ps

package imt_pkg;

    // Field widths of the pixel and result beats.
    localparam int STR_W      = 16;
    localparam int ORIENT_W   = 16;
    localparam int STORE_W    = STR_W + 1;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int M_USED_W   = STR_W + 1;

    // Convergence test: diff * 200 < 2^FRAC_BITS.
    localparam int CONV_W     = 25;
    localparam logic [CONV_W-1:0] CONV_MUL = 25'd200;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_LOAD     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_DIV_GO   = 6'b000100,
        ST_DIV_WAIT = 6'b001000,
        ST_UPDATE   = 6'b010000,
        ST_OUT      = 6'b100000
    } imt_state_t;

    // Which class mean the divider is working on.
    typedef enum logic {
        PH_SEL = 1'b0,
        PH_REJ = 1'b1
    } imt_phase_t;

endpackage

// ===== hw/rtl/iterative_mean_threshold.sv =====
// Top level of the iterative mean threshold block: sequencer, scan datapath.
// Depends on imt_pkg, imt_ram and imt_div.
`timescale 1ns / 1ps

// Pixels stream in one beat per cycle while s_axis_tready is high and are kept
// in an internal store. The beat with tlast closes the frame; the block then
// drops s_axis_tready and refines the strength cutoff by repeated passes over
// the stored frame, one pixel read per cycle from the store's read port. Each
// pass is a scan of the N stored pixels, two serial divisions on the shared
// divider (one step per bit of the 16 + clog2(MAX_PIXELS + 1) bit class sum),
// and an update step. When no cutoff is held yet, one extra scan and one
// division compute the starting value. A frame thus takes its load plus up to
// MAX_PASSES such passes, one more when the starting pass runs. Only the
// tlast beat produces a result beat; the cutoff is kept across frames. Pixels
// beyond MAX_PIXELS are dropped. The store needs no clearing after reset.
module iterative_mean_threshold
    import imt_pkg::*;
#(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_PASSES = 10,
    parameter int FRAC_BITS  = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: orientation[15:0], strength[31:16].
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: req_type.
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: cutoff_out[15:0], converged[16], zero padding.
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW   = $clog2(MAX_PIXELS + 1);
    localparam int SW   = STR_W + CW;
    localparam int PW   = $clog2(MAX_PASSES + 1);
    localparam logic signed [23:0] ORIENT_LIM = 24'(7 * (2 ** FRAC_BITS));
    localparam logic [20:0]        STR_TOP    = 21'(10 * (2 ** FRAC_BITS));
    localparam logic [CONV_W-1:0]  CONV_ONE   = CONV_W'(2 ** FRAC_BITS);

    imt_state_t       state_reg, state_next;
    imt_phase_t       phase_reg;
    logic             init_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    idx_reg;
    logic             rvalid_reg;
    logic [SW-1:0]    sum_sel_reg, sum_rej_reg;
    logic [CW-1:0]    cnt_sel_reg;
    logic [STR_W-1:0] cutoff_reg, mean_sel_reg, mean_rej_reg;
    logic [PW-1:0]    pass_reg;
    logic             m_valid_reg;
    logic [STR_W-1:0] m_cutoff_reg;
    logic             m_conv_reg, conv_reg;

    logic             s_beat, m_beat;
    logic             orient_ok;
    logic [STORE_W-1:0] wdata, rdata;
    logic             rd_sel;
    logic             scan_issue, scan_done;
    logic             div_start, div_done;
    logic [SW-1:0]    div_dvd;
    logic [CW-1:0]    div_dvs, cnt_rej;
    logic [STR_W-1:0] div_q;
    logic [STR_W:0]   nc_sum;
    logic [STR_W-1:0] nc, diff;
    logic             conv_now, last_pass;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_beat = m_valid_reg && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_LOAD);

    // Orientation window check, done on the way into the store.
    assign orient_ok = ($signed({{8{s_axis_tdata[15]}}, s_axis_tdata[15:0]}) >= -ORIENT_LIM)
                    && ($signed({{8{s_axis_tdata[15]}}, s_axis_tdata[15:0]}) <= ORIENT_LIM);
    assign wdata = {orient_ok, s_axis_tdata[31:16]};

    imt_ram #(.WIDTH(STORE_W), .DEPTH(MAX_PIXELS)) u_store (
        .aclk  (aclk),
        .we    (s_beat && count_reg < CW'(MAX_PIXELS)),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    // Scan control: one read issued per cycle, its data arriving in the next cycle.
    assign scan_issue = (state_reg == ST_SCAN) && (idx_reg != count_reg);
    assign scan_done  = (state_reg == ST_SCAN) && (idx_reg == count_reg) && !rvalid_reg;
    assign rd_sel = !init_reg && rdata[STR_W]
                 && rdata[STR_W-1:0] >= cutoff_reg
                 && {5'b0, rdata[STR_W-1:0]} <= STR_TOP;

    // Divider operands for the class in progress.
    assign cnt_rej = CW'(count_reg - cnt_sel_reg);
    assign div_start = (state_reg == ST_DIV_GO);
    assign div_dvd = (phase_reg == PH_SEL) ? sum_sel_reg : sum_rej_reg;
    assign div_dvs = (phase_reg == PH_SEL) ? cnt_sel_reg : cnt_rej;

    imt_div #(.DVD_W(SW), .DVS_W(CW), .Q_W(STR_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Cutoff update and convergence test.
    assign nc_sum    = {1'b0, mean_sel_reg} + {1'b0, mean_rej_reg};
    assign nc        = nc_sum[STR_W:1];
    assign diff      = (nc >= cutoff_reg) ? STR_W'(nc - cutoff_reg) : STR_W'(cutoff_reg - nc);
    assign conv_now  = (CONV_W'(diff) * CONV_MUL) < CONV_ONE;
    assign last_pass = (pass_reg == PW'(MAX_PASSES - 1));

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:     if (s_beat && s_axis_tlast) state_next = ST_SCAN;
            ST_SCAN:     if (scan_done) state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (phase_reg == PH_SEL) ? ST_DIV_GO : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (init_reg) begin
                    state_next = ST_SCAN;
                end else if (conv_now || last_pass) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_OUT:      if (!m_valid_reg || m_axis_tready) state_next = ST_LOAD;
            default:     state_next = ST_LOAD;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            cutoff_reg  <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            init_reg    <= 1'b0;
            phase_reg   <= PH_SEL;
            pass_reg    <= '0;
            idx_reg     <= '0;
            conv_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rvalid_reg <= scan_issue;
            if (scan_issue) begin
                idx_reg <= CW'(idx_reg + 1'b1);
            end
            // In the output state the case below decides the valid flag.
            if (m_beat && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_beat && count_reg < CW'(MAX_PIXELS)) begin
                        count_reg <= CW'(count_reg + 1'b1);
                    end
                    if (s_beat && s_axis_tlast) begin
                        init_reg <= (cutoff_reg == '0);
                        pass_reg <= '0;
                        idx_reg  <= '0;
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        phase_reg <= init_reg ? PH_REJ : PH_SEL;
                    end
                end
                ST_DIV_GO: ;
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        phase_reg <= PH_REJ;
                    end
                end
                ST_UPDATE: begin
                    idx_reg <= '0;
                    if (init_reg) begin
                        cutoff_reg <= {1'b0, mean_rej_reg[STR_W-1:1]};
                        init_reg   <= 1'b0;
                    end else begin
                        cutoff_reg <= nc;
                        conv_reg   <= conv_now;
                        pass_reg   <= PW'(pass_reg + 1'b1);
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        count_reg   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Accumulators, class means and the output beat.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            sum_sel_reg <= '0;
            sum_rej_reg <= '0;
            cnt_sel_reg <= '0;
        end else if (state_reg == ST_UPDATE) begin
            sum_sel_reg <= '0;
            sum_rej_reg <= '0;
            cnt_sel_reg <= '0;
        end else if (rvalid_reg) begin
            if (rd_sel) begin
                sum_sel_reg <= SW'(sum_sel_reg + rdata[STR_W-1:0]);
                cnt_sel_reg <= CW'(cnt_sel_reg + 1'b1);
            end else begin
                sum_rej_reg <= SW'(sum_rej_reg + rdata[STR_W-1:0]);
            end
        end
        if (state_reg == ST_DIV_WAIT && div_done) begin
            if (phase_reg == PH_SEL) begin
                mean_sel_reg <= (div_dvs == '0) ? '0 : div_q;
            end else begin
                mean_rej_reg <= (div_dvs == '0) ? '0 : div_q;
            end
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_axis_tready)) begin
            m_cutoff_reg <= cutoff_reg;
            m_conv_reg   <= conv_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - M_USED_W)'(0), m_conv_reg, m_cutoff_reg};

endmodule

// ===== hw/rtl/imt_ram.sv =====
// Generic RAM with one write port and one registered read port for the pixel store.
// No dependencies.
`timescale 1ns / 1ps

module imt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/imt_div.sv =====
// Restoring divider, one quotient bit per cycle, shared for all class means.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module imt_div #(
    parameter int DVD_W = 33,
    parameter int DVS_W = 17,
    parameter int Q_W   = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic             take;

    // One shift-and-subtract step.
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        take     = trial >= {1'b0, dvs_reg};
        rem_next = take ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], take};
        cnt_next = CNT_W'(cnt_reg + 1'b1);
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == CNT_W'(DVD_W - 1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[Q_W-1:0];

endmodule

// ===== hw/rtl/imt_chk.sv =====
// Port-level checker for the iterative mean threshold block, with its bind.
// Depends on imt_pkg and the top level iterative_mean_threshold.
`timescale 1ns / 1ps

module imt_chk
    import imt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tlast,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result beat keeps its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The closing beat of a frame stops intake for the refinement.
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after frame end");

    // A new result appears only while intake is held off.
    a_rose: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result produced during frame load");

    // Padding bits of the result beat stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:M_USED_W] == '0)
        else $error("nonzero padding in result beat");

endmodule

bind iterative_mean_threshold imt_chk u_imt_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
